[src/pseu_pkg.sv]
// shared types and helpers for the particle store euler update unit
// no dependencies
`default_nettype none
package pseu_pkg;

  localparam int GRAV_W = 31;
  localparam logic [GRAV_W-1:0] GRAV_RESET = 31'd2569011;
  localparam int OUT_CNT_W = 11;
  localparam int LAYER_W = 3;
  localparam int DT_W = 17;
  localparam int PROD_W = 51;
  localparam int FX_W = 35;
  localparam logic [PROD_W-1:0] ROUND_HALF = 51'h8000;

  // register indexes on the config port
  localparam logic REG_GRAVITY = 1'b0;

  // one particle record as held in the slot memory
  typedef struct packed {
    logic                valid;
    logic [LAYER_W-1:0]  layer;
    logic                has_floor;
    logic                has_gravity;
    logic signed [31:0]  px;
    logic signed [31:0]  py;
    logic signed [31:0]  vx;
    logic signed [31:0]  vy;
    logic [31:0]         age;
    logic [30:0]         life;
    logic [31:0]         angle;
    logic signed [31:0]  spin;
    logic signed [32:0]  floor_y;
  } slot_t;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_READ  = 9'b000000100,
    ST_EVAL  = 9'b000001000,
    ST_VY    = 9'b000010000,
    ST_PX    = 9'b000100000,
    ST_PY    = 9'b001000000,
    ST_ANG   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  // rounded fixed-point step: floor((p + 32768) / 65536)
  function automatic logic signed [FX_W-1:0] fx_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + $signed(ROUND_HALF);
    return s[PROD_W-1:16];
  endfunction

  // add a rounded step to a 32 bit value and saturate
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [FX_W-1:0] b);
    logic signed [FX_W:0] s;
    s = (FX_W+1)'(a) + (FX_W+1)'(b);
    if (s > (FX_W+1)'(signed'(32'sh7fffffff))) return 32'sh7fffffff;
    else if (s < (FX_W+1)'(signed'(32'sh80000000))) return 32'sh80000000;
    else return s[31:0];
  endfunction

endpackage
`default_nettype wire

[src/pseu_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module pseu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/particle_store_euler_update_unit.sv]
// particle store with semi-implicit euler update, q16.16 fixed point
// depends on pseu_pkg and pseu_ram
//
//   channel  | signals                         | direction
//   in       | in_valid/in_ready + fields      | spawn or tick transaction in
//   out      | out_valid/out_ready + fields    | one result per transaction
//   apb      | psel penable pwrite paddr ...   | gravity_accel register
//
// spawn: slots are read and evaluated in turn up to the lowest free slot
// tick: every slot is read and evaluated, a surviving slot also steps vy, px,
//   py and angle, over all STORE_DEPTH slots unless none are alive; the single slot
//   memory port and the shared 33x18 multiplier (four products per survivor) set these steps
// after reset a clear pass writes every slot to zero before in_ready rises
// a finished result waits in the output register; the next transaction is
// taken meanwhile and holds at its end until the output register is free
`default_nettype none
module particle_store_euler_update_unit
  import pseu_pkg::*;
#(
  parameter int STORE_DEPTH = 1024,
  parameter int LAYER_COUNT = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               command,
  input  wire logic [2:0]         layer,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic signed [31:0] spin,
  input  wire logic [30:0]        lifetime,
  input  wire logic signed [31:0] floor_offset,
  input  wire logic               has_floor,
  input  wire logic               has_gravity,
  input  wire logic [16:0]        dt,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    status,
  output logic [10:0]             total_alive,
  output logic [10:0]             deaths,
  output logic [7:0]              layers_emptied,
  output logic [31:0]             elapsed_time,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int LAYERS_USED = (LAYER_COUNT < 8) ? LAYER_COUNT : 8;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);

  state_t state;
  logic [GRAV_W-1:0] gravity_accel;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] alive_total;
  logic [CNT_W-1:0] death_cnt;
  logic [CNT_W-1:0] layer_alive [LAYERS_USED];
  logic [7:0] died_layers;
  logic [31:0] time_sum;
  logic drop;
  logic cmd_tick;

  // captured spawn transaction
  logic [LAYER_W-1:0] sp_layer;
  logic signed [31:0] sp_px, sp_py, sp_vx, sp_vy, sp_spin;
  logic [30:0] sp_life;
  logic signed [32:0] sp_floor;
  logic sp_has_floor, sp_has_grav;
  logic [DT_W-1:0] cur_dt;

  slot_t cur;
  slot_t rdata;
  slot_t wdata;
  slot_t aged;
  logic ram_we;

  logic signed [32:0] mul_a;
  logic signed [PROD_W-1:0] prod;
  logic signed [FX_W-1:0] fx;

  logic [32:0] age_sum;
  logic [31:0] age_new;
  logic dead;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_GRAVITY) ? {1'b0, gravity_accel} : 32'd0;
  assign in_ready = (state == ST_IDLE);

  pseu_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (STORE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  assign fx = fx_round(prod);
  assign age_sum = {1'b0, rdata.age} + 33'(cur_dt);
  assign age_new = age_sum[32] ? 32'hffffffff : age_sum[31:0];
  assign dead = (age_new >= {1'b0, rdata.life}) ||
                (rdata.has_floor && (33'(rdata.py) <= rdata.floor_y));

  // slot as read, with its age already advanced
  always_comb begin
    aged = rdata;
    aged.age = age_new;
  end

  // shared multiplier operand, one product per step
  always_comb begin
    unique case (state)
      ST_EVAL: mul_a = rdata.has_gravity ? -$signed({2'b00, gravity_accel}) : 33'sd0;
      ST_VY:   mul_a = 33'(cur.vx);
      ST_PX:   mul_a = 33'(cur.vy);
      ST_PY:   mul_a = 33'(cur.spin);
      default: mul_a = 33'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * $signed({1'b0, cur_dt});
  end

  always_comb begin
    ram_we = 1'b0;
    wdata = cur;
    priority if (state == ST_CLEAR) begin
      ram_we = 1'b1;
      wdata = '0;
    end else if (state == ST_EVAL && !cmd_tick && !rdata.valid) begin
      ram_we = 1'b1;
      wdata.valid = 1'b1;
      wdata.layer = sp_layer;
      wdata.has_floor = sp_has_floor;
      wdata.has_gravity = sp_has_grav;
      wdata.px = sp_px;
      wdata.py = sp_py;
      wdata.vx = sp_vx;
      wdata.vy = sp_vy;
      wdata.age = 32'd0;
      wdata.life = sp_life;
      wdata.angle = 32'd0;
      wdata.spin = sp_spin;
      wdata.floor_y = sp_floor;
    end else if (state == ST_EVAL && cmd_tick && rdata.valid && dead) begin
      ram_we = 1'b1;
      wdata = rdata;
      wdata.valid = 1'b0;
    end else if (state == ST_ANG) begin
      ram_we = 1'b1;
      wdata.angle = cur.angle + fx[31:0];
    end else begin
      ram_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      idx <= '0;
      gravity_accel <= GRAV_RESET;
      alive_total <= '0;
      time_sum <= '0;
      out_valid <= 1'b0;
      for (int l = 0; l < LAYERS_USED; l++) begin
        layer_alive[l] <= '0;
      end
    end else begin
      if (cfg_wr && paddr[2] == REG_GRAVITY) begin
        gravity_accel <= pwdata[GRAV_W-1:0];
      end
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (idx == LAST_IDX) begin
            idx <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cmd_tick <= command;
            cur_dt <= dt;
            sp_layer <= layer;
            sp_px <= pos_x;
            sp_py <= pos_y;
            sp_vx <= vel_x;
            sp_vy <= vel_y;
            sp_spin <= spin;
            sp_life <= lifetime;
            sp_floor <= 33'(pos_y) + 33'(floor_offset);
            sp_has_floor <= has_floor;
            sp_has_grav <= has_gravity;
            death_cnt <= '0;
            died_layers <= '0;
            idx <= '0;
            if (command) begin
              drop <= 1'b0;
              time_sum <= time_sum + 32'(dt);
              state <= (alive_total == '0) ? ST_DONE : ST_READ;
            end else if (alive_total >= CNT_W'(STORE_DEPTH)) begin
              drop <= 1'b1;
              state <= ST_DONE;
            end else if (32'(layer) >= LAYER_COUNT) begin
              drop <= 1'b0;
              state <= ST_DONE;
            end else begin
              drop <= 1'b0;
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (!cmd_tick) begin
            if (!rdata.valid) begin
              alive_total <= alive_total + 1'b1;
              for (int l = 0; l < LAYERS_USED; l++) begin
                if (3'(l) == sp_layer) layer_alive[l] <= layer_alive[l] + 1'b1;
              end
              state <= ST_DONE;
            end else begin
              idx <= idx + 1'b1;
              state <= ST_READ;
            end
          end else if (rdata.valid && !dead) begin
            cur <= aged;
            state <= ST_VY;
          end else begin
            if (rdata.valid) begin
              death_cnt <= death_cnt + 1'b1;
              if (alive_total != '0) alive_total <= alive_total - 1'b1;
              for (int l = 0; l < LAYERS_USED; l++) begin
                if (3'(l) == rdata.layer) begin
                  died_layers[l] <= 1'b1;
                  if (layer_alive[l] != '0) layer_alive[l] <= layer_alive[l] - 1'b1;
                end
              end
            end
            if (idx == LAST_IDX) begin
              state <= ST_DONE;
            end else begin
              idx <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        ST_VY: begin
          cur.vy <= sat_add(cur.vy, fx);
          state <= ST_PX;
        end
        ST_PX: begin
          cur.px <= sat_add(cur.px, fx);
          state <= ST_PY;
        end
        ST_PY: begin
          cur.py <= sat_add(cur.py, fx);
          state <= ST_ANG;
        end
        ST_ANG: begin
          if (idx == LAST_IDX) begin
            state <= ST_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= ST_READ;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status <= drop;
            total_alive <= OUT_CNT_W'(alive_total);
            deaths <= OUT_CNT_W'(death_cnt);
            elapsed_time <= time_sum;
            for (int l = 0; l < 8; l++) begin
              if (l < LAYERS_USED) begin
                layers_emptied[l] <= died_layers[l] && (layer_alive[l] == '0);
              end else begin
                layers_emptied[l] <= 1'b0;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/pseu_checker.sv]
// port-level checks for particle_store_euler_update_unit, bound to the top level
// depends on nothing but the top level's ports
`default_nettype none
module pseu_checker #(
  parameter int STORE_DEPTH = 1024
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        status,
  input wire logic [10:0] total_alive,
  input wire logic [10:0] deaths,
  input wire logic [7:0]  layers_emptied
);

  // a held result stays until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // the block works on one transaction at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // a dropped spawn reports no deaths
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> deaths == 11'd0 && layers_emptied == 8'd0)
    else $error("dropped spawn with deaths");

  // a layer can only empty when something died
  assert property (@(posedge clk) disable iff (rst)
    out_valid && deaths == 11'd0 |-> layers_emptied == 8'd0)
    else $error("layer emptied without deaths");

  // store never over full
  assert property (@(posedge clk) disable iff (rst)
    out_valid && STORE_DEPTH < 2048 |-> 32'(total_alive) <= STORE_DEPTH)
    else $error("alive count above store depth");

endmodule

bind particle_store_euler_update_unit pseu_checker #(.STORE_DEPTH(STORE_DEPTH)) u_pseu_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .total_alive    (total_alive),
  .deaths         (deaths),
  .layers_emptied (layers_emptied)
);
`default_nettype wire
